// ----- rtl/core/scrh_pkg.sv -----
// Shared types and codes for the sorted circle hit register.
package scrh_pkg;

   // Operation codes carried by a request beat.
   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_SHOT = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   // Controller states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CHK,
      S_INS_PLACE,
      S_SHOT,
      S_BS_RD,
      S_BS_CHK,
      S_TST_RD,
      S_TST_DX,
      S_TST_SQ,
      S_TST_CMP,
      S_TST_UPD,
      S_READ,
      S_READ_WAIT,
      S_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic shot_start;
      logic ins_rd;
      logic ins_shift;
      logic ins_place;
      logic bs_rd;
      logic bs_step;
      logic tst_rd;
      logic tst_second;
      logic tst_dx;
      logic tst_sq;
      logic tst_cmp;
      logic tst_upd;
      logic rd_fh;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic count_zero;
      logic table_full;
      logic pos_zero;
      logic shift_need;
      logic bs_done;
      logic found_zero;
   } status_type;

endpackage

// ----- rtl/core/scrh_ctrl.sv -----
// Controller state machine that sequences add, shot and read operations.
module scrh_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_operation,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output scrh_pkg::cmd_type    cmd,
   input  scrh_pkg::status_type status
);
   import scrh_pkg::*;

   state_type state_ff, state_in;
   logic      second_ff, second_in;
   logic      rsp_valid_ff, rsp_valid_in;
   op_type    req_op;

   assign req_op    = op_type'(req_operation);
   assign rsp_valid = rsp_valid_ff;
   assign req_ready = (state_ff == S_IDLE);

   // State, second-target flag and output valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in       = state_ff;
      second_in      = second_ff;
      cmd            = '0;
      cmd.tst_second = second_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (req_op)
                  OP_ADD:  state_in = status.table_full ? S_RESP : S_INS_RD;
                  OP_SHOT: state_in = S_SHOT;
                  OP_READ: state_in = S_READ;
                  OP_NONE: state_in = S_RESP;
               endcase
            end
         end
         S_INS_RD: begin
            if (status.pos_zero) begin
               state_in = S_INS_PLACE;
            end else begin
               cmd.ins_rd = 1'b1;
               state_in   = S_INS_CHK;
            end
         end
         S_INS_CHK: begin
            if (status.shift_need) begin
               cmd.ins_shift = 1'b1;
               state_in      = S_INS_RD;
            end else begin
               state_in = S_INS_PLACE;
            end
         end
         S_INS_PLACE: begin
            cmd.ins_place = 1'b1;
            state_in      = S_RESP;
         end
         S_SHOT: begin
            cmd.shot_start = 1'b1;
            second_in      = 1'b0;
            state_in       = status.count_zero ? S_RESP : S_BS_RD;
         end
         S_BS_RD: begin
            if (status.bs_done) begin
               state_in = S_TST_RD;
            end else begin
               cmd.bs_rd = 1'b1;
               state_in  = S_BS_CHK;
            end
         end
         S_BS_CHK: begin
            cmd.bs_step = 1'b1;
            state_in    = S_BS_RD;
         end
         S_TST_RD: begin
            cmd.tst_rd = 1'b1;
            state_in   = S_TST_DX;
         end
         S_TST_DX: begin
            cmd.tst_dx = 1'b1;
            state_in   = S_TST_SQ;
         end
         S_TST_SQ: begin
            cmd.tst_sq = 1'b1;
            state_in   = S_TST_CMP;
         end
         S_TST_CMP: begin
            cmd.tst_cmp = 1'b1;
            state_in    = S_TST_UPD;
         end
         S_TST_UPD: begin
            cmd.tst_upd = 1'b1;
            if (!second_ff && !status.found_zero) begin
               second_in = 1'b1;
               state_in  = S_TST_RD;
            end else begin
               state_in = S_RESP;
            end
         end
         S_READ: begin
            cmd.rd_fh = 1'b1;
            state_in  = S_READ_WAIT;
         end
         S_READ_WAIT: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// ----- rtl/core/scrh_dp.sv -----
// Datapath: sorted target table, first-hit store, counters and circle test.
module scrh_dp #(
   parameter int MAX_TARGETS = 1024
) (
   input  logic                 clock,
   input  logic                 reset,
   input  scrh_pkg::cmd_type    cmd,
   output scrh_pkg::status_type status,
   input  logic [1:0]           req_operation,
   input  logic signed [15:0]   req_center,
   input  logic [14:0]          req_radius,
   input  logic signed [15:0]   req_shot_x,
   input  logic signed [15:0]   req_shot_y,
   input  logic [9:0]           req_target_index,
   output logic [19:0]          rsp_first_hit,
   output logic [1:0]           rsp_new_hits,
   output logic [10:0]          rsp_targets_hit,
   output logic                 rsp_table_full
);
   import scrh_pkg::*;

   localparam int IW   = $clog2(MAX_TARGETS);
   localparam int CW   = $clog2(MAX_TARGETS + 1);
   localparam int CMPW = (CW > 10) ? CW : 10;
   localparam logic [19:0] SHOT_MAX = 20'hFFFFF;

   // Sorted table and first-hit store.
   logic signed [15:0] ctr_mem [MAX_TARGETS];
   logic [14:0]        rad_mem [MAX_TARGETS];
   logic [IW-1:0]      org_mem [MAX_TARGETS];
   logic [19:0]        fh_mem  [MAX_TARGETS];

   // Captured request.
   op_type             op_ff;
   logic signed [15:0] c_ff, x_ff, y_ff;
   logic [14:0]        r_ff;
   logic [9:0]         idx_ff;

   // Control counters and search pointers.
   logic [CW-1:0] count_ff, hits_ff, lo_ff, hi_ff, mid_ff;
   logic [IW-1:0] pos_ff, found_ff;
   logic [19:0]   shot_ff;
   logic [1:0]    newhits_ff;
   logic          full_ff, rd_ok_ff;

   // Table read data and circle test pipeline.
   logic signed [15:0] rd_ctr_ff;
   logic [14:0]        rd_rad_ff;
   logic [IW-1:0]      rd_org_ff;
   logic [19:0]        fh_rd_ff;
   logic [15:0]        dx_ff;
   logic [14:0]        rad_ff;
   logic [IW-1:0]      org_ff;
   logic [31:0]        ysq_ff;
   logic [32:0]        dsq_ff;
   logic [29:0]        rsq_ff;
   logic               in_ff;

   // Output payload registers.
   logic [19:0] out_fh_ff;
   logic [1:0]  out_nh_ff;
   logic [10:0] out_th_ff;
   logic        out_full_ff;

   logic [CW-1:0]      mid_w;
   logic [IW-1:0]      tst_addr;
   logic [IW-1:0]      tbl_rd_addr;
   logic signed [16:0] diff_w;
   logic [15:0]        y_abs;
   logic [CW-1:0]      max_cnt;

   assign max_cnt  = CW'(MAX_TARGETS);
   assign mid_w    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign tst_addr = cmd.tst_second ? (found_ff - IW'(1)) : found_ff;
   assign diff_w   = 17'(rd_ctr_ff) - 17'(x_ff);
   assign y_abs    = y_ff[15] ? 16'(-17'(y_ff)) : 16'(y_ff);

   // Status toward the controller.
   assign status.count_zero = (count_ff == '0);
   assign status.table_full = (count_ff == max_cnt);
   assign status.pos_zero   = (pos_ff == '0);
   assign status.shift_need = (rd_ctr_ff > c_ff);
   assign status.bs_done    = (lo_ff >= hi_ff);
   assign status.found_zero = (found_ff == '0);

   // Table read address select.
   always_comb begin
      priority if (cmd.ins_rd) tbl_rd_addr = pos_ff - IW'(1);
      else if (cmd.bs_rd)      tbl_rd_addr = mid_w[IW-1:0];
      else                     tbl_rd_addr = tst_addr;
   end

   // Sorted table: one registered read and one write per cycle.
   always_ff @(posedge clock) begin
      if (cmd.ins_rd || cmd.bs_rd || cmd.tst_rd) begin
         rd_ctr_ff <= ctr_mem[tbl_rd_addr];
         rd_rad_ff <= rad_mem[tbl_rd_addr];
         rd_org_ff <= org_mem[tbl_rd_addr];
      end
      if (cmd.ins_shift) begin
         ctr_mem[pos_ff] <= rd_ctr_ff;
         rad_mem[pos_ff] <= rd_rad_ff;
         org_mem[pos_ff] <= rd_org_ff;
      end else if (cmd.ins_place) begin
         ctr_mem[pos_ff] <= c_ff;
         rad_mem[pos_ff] <= r_ff;
         org_mem[pos_ff] <= count_ff[IW-1:0];
      end
   end

   // First-hit store: entries are cleared as targets are added.
   always_ff @(posedge clock) begin
      if (cmd.rd_fh) begin
         fh_rd_ff <= fh_mem[IW'(idx_ff)];
      end else if (cmd.tst_cmp) begin
         fh_rd_ff <= fh_mem[org_ff];
      end
      if (cmd.ins_place) begin
         fh_mem[count_ff[IW-1:0]] <= '0;
      end else if (cmd.tst_upd && in_ff && fh_rd_ff == '0) begin
         fh_mem[org_ff] <= shot_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         hits_ff  <= '0;
         shot_ff  <= '0;
      end else begin
         if (cmd.ins_place) begin
            count_ff <= count_ff + CW'(1);
         end
         if (cmd.shot_start && shot_ff != SHOT_MAX) begin
            shot_ff <= shot_ff + 20'd1;
         end
         if (cmd.tst_upd && in_ff && fh_rd_ff == '0) begin
            hits_ff <= hits_ff + CW'(1);
         end
      end
   end

   // Request capture, search and test pipeline.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= op_type'(req_operation);
         c_ff       <= req_center;
         r_ff       <= req_radius;
         x_ff       <= req_shot_x;
         y_ff       <= req_shot_y;
         idx_ff     <= req_target_index;
         pos_ff     <= count_ff[IW-1:0];
         newhits_ff <= '0;
         full_ff    <= (op_type'(req_operation) == OP_ADD) && (count_ff == max_cnt);
         rd_ok_ff   <= 1'b0;
      end
      if (cmd.ins_shift) begin
         pos_ff <= pos_ff - IW'(1);
      end
      if (cmd.shot_start) begin
         lo_ff    <= '0;
         hi_ff    <= count_ff;
         found_ff <= IW'(count_ff - CW'(1));
         ysq_ff   <= y_abs * y_abs;
      end
      if (cmd.bs_rd) begin
         mid_ff <= mid_w;
      end
      if (cmd.bs_step) begin
         if (rd_ctr_ff < x_ff) begin
            lo_ff <= mid_ff + CW'(1);
         end else begin
            hi_ff    <= mid_ff;
            found_ff <= mid_ff[IW-1:0];
         end
      end
      if (cmd.tst_dx) begin
         dx_ff  <= diff_w[16] ? 16'(-diff_w) : diff_w[15:0];
         rad_ff <= rd_rad_ff;
         org_ff <= rd_org_ff;
      end
      if (cmd.tst_sq) begin
         dsq_ff <= 33'(dx_ff * dx_ff) + 33'(ysq_ff);
         rsq_ff <= rad_ff * rad_ff;
      end
      if (cmd.tst_cmp) begin
         in_ff <= (33'(rsq_ff) >= dsq_ff);
      end
      if (cmd.tst_upd && in_ff && fh_rd_ff == '0) begin
         newhits_ff <= newhits_ff + 2'd1;
      end
      if (cmd.rd_fh) begin
         rd_ok_ff <= (CMPW'(idx_ff) < CMPW'(count_ff));
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         out_fh_ff   <= (op_ff == OP_READ && rd_ok_ff) ? fh_rd_ff : '0;
         out_nh_ff   <= (op_ff == OP_SHOT) ? newhits_ff : '0;
         out_th_ff   <= 11'(hits_ff);
         out_full_ff <= full_ff;
      end
   end

   assign rsp_first_hit   = out_fh_ff;
   assign rsp_new_hits    = out_nh_ff;
   assign rsp_targets_hit = out_th_ff;
   assign rsp_table_full  = out_full_ff;

   // A target can be hit only once, so hits never pass the target count.
   a_hits_le_count: assert property (@(posedge clock) disable iff (reset)
      hits_ff <= count_ff) else $error("hit total exceeds target count");

   // The table never holds more than its capacity.
   a_count_le_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= max_cnt) else $error("target count exceeds capacity");

   // A shot hits at most two targets.
   a_newhits_le_two: assert property (@(posedge clock) disable iff (reset)
      cmd.tst_upd |-> newhits_ff != 2'd3) else $error("more than two new hits");

   // Inserting only happens while the table has room.
   a_place_room: assert property (@(posedge clock) disable iff (reset)
      cmd.ins_place |-> count_ff < max_cnt) else $error("insert into full table");

endmodule

// ----- rtl/core/sorted_circle_hit_register.sv -----
// Top level of the sorted circle hit register.
//
// Request beats carry an operation: add a target (center, radius), fire a
// shot (shot_x, shot_y) or read a target's first-hit shot (target_index).
// Every request beat yields exactly one response beat carrying first_hit,
// new_hits, targets_hit and table_full.
// One request is worked on at a time; req_ready is high only while idle.
// Steps from accept to response valid:
//   add:  a table shift loop moves each stored target with a larger center
//         one place back, then the new target is placed; a full table goes
//         straight to the response.
//   shot: a binary search (about log2 of the target count steps, one table
//         read each), then a circle test of one or two targets; an empty
//         table goes straight to the response.
//   read: one first-hit store read; unused operation: straight to the response.
// The binary search and the insert shift are bound by the single table
// read port. The response sits in an output register: a new request is
// accepted while it waits, and if the receiver stalls the next result waits
// until the register is taken. Reset empties the table and clears the shot
// counter and hit total; no clearing pass is needed.
module sorted_circle_hit_register #(
   parameter int MAX_TARGETS = 1024
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic signed [15:0] req_center,
   input  logic [14:0]        req_radius,
   input  logic signed [15:0] req_shot_x,
   input  logic signed [15:0] req_shot_y,
   input  logic [9:0]         req_target_index,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [19:0]        rsp_first_hit,
   output logic [1:0]         rsp_new_hits,
   output logic [10:0]        rsp_targets_hit,
   output logic               rsp_table_full
);
   import scrh_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   scrh_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .cmd           (cmd),
      .status        (status)
   );

   // Table, counters and arithmetic.
   scrh_dp #(
      .MAX_TARGETS (MAX_TARGETS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_center       (req_center),
      .req_radius       (req_radius),
      .req_shot_x       (req_shot_x),
      .req_shot_y       (req_shot_y),
      .req_target_index (req_target_index),
      .rsp_first_hit    (rsp_first_hit),
      .rsp_new_hits     (rsp_new_hits),
      .rsp_targets_hit  (rsp_targets_hit),
      .rsp_table_full   (rsp_table_full)
   );

endmodule
